>>> rtl/rmp_pkg.sv
// ----------------------------------------------------------------------------
// rmp_pkg
// Shared types, constants and helpers for the ROI max pooling core.
// ----------------------------------------------------------------------------
package rmp_pkg;

  localparam int MAX_BATCH    = 2;
  localparam int MAX_CHANNELS = 8;
  localparam int MAX_HEIGHT   = 32;
  localparam int MAX_WIDTH    = 32;
  localparam int MAX_POOLED   = 16;

  localparam int BATCH_W     = 1;
  localparam int CH_W        = 3;
  localparam int ROW_W       = 5;
  localparam int COL_W       = 5;
  localparam int ADDR_W      = BATCH_W + CH_W + ROW_W + COL_W;
  localparam int STORE_DEPTH = MAX_BATCH * MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;

  localparam int VALUE_W     = 16;
  localparam int ROI_W       = 16;
  localparam int SCALE_W     = 16;
  localparam int PROD_W      = ROI_W + SCALE_W + 1;
  localparam int ROUND_SHIFT = 20;
  localparam int COORD_W     = 13;
  localparam int SIZE_W      = 13;
  localparam int BIN_W       = 4;
  localparam int POOL_W      = 5;
  localparam int MAP_W       = 6;
  localparam int NUM_W       = 17;
  localparam int SUM_W       = NUM_W + 1;
  localparam int REM_W       = POOL_W;
  localparam int DIV_STEPS   = NUM_W;
  localparam int DCNT_W      = 5;
  localparam int LANES       = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_POOL = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOLED_ROWS = 3'd0,
    REG_POOLED_COLS = 3'd1,
    REG_MAP_SCALE   = 3'd2,
    REG_MAP_HEIGHT  = 3'd3,
    REG_MAP_WIDTH   = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_DROP,
    KIND_POOL,
    KIND_BAD
  } item_kind_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SCALE,
    B_SIZE,
    B_DIV,
    B_CLIP,
    B_SCAN,
    B_DRAIN,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic                      req_type;
    logic [BATCH_W-1:0]        batch_index;
    logic [CH_W-1:0]           channel_index;
    logic [ROW_W-1:0]          load_row;
    logic [COL_W-1:0]          load_col;
    logic signed [VALUE_W-1:0] load_value;
    logic [ROI_W-1:0]          roi_left;
    logic [ROI_W-1:0]          roi_top;
    logic [ROI_W-1:0]          roi_right;
    logic [ROI_W-1:0]          roi_bottom;
    logic [BIN_W-1:0]          bin_row;
    logic [BIN_W-1:0]          bin_col;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] pooled_value;
    logic                      empty_bin;
    logic                      bad_request;
  } rsp_t;

  typedef struct packed {
    logic [POOL_W-1:0]  pooled_rows;
    logic [POOL_W-1:0]  pooled_cols;
    logic [SCALE_W-1:0] map_scale;
    logic [MAP_W-1:0]   map_height;
    logic [MAP_W-1:0]   map_width;
  } cfg_t;

  typedef struct packed {
    item_kind_t kind;
    req_t       req;
  } qentry_t;

  function automatic logic [POOL_W-1:0] sat_pool(input logic [POOL_W-1:0] v);
    return (v > POOL_W'(MAX_POOLED)) ? POOL_W'(MAX_POOLED) : v;
  endfunction

  function automatic logic [MAP_W-1:0] sat_map(input logic [MAP_W-1:0] v,
                                               input logic [MAP_W-1:0] lim);
    return (v > lim) ? lim : v;
  endfunction

  function automatic logic [MAP_W-1:0] clip_map(input logic [SUM_W-1:0] v,
                                                input logic [MAP_W-1:0] lim);
    return (v > SUM_W'(lim)) ? lim : v[MAP_W-1:0];
  endfunction

endpackage

>>> rtl/roi_max_pooling_core.sv
// ----------------------------------------------------------------------------
// roi_max_pooling_core
// ROI max pooling over a local feature store with a config register port.
// ----------------------------------------------------------------------------
// A load transaction (req_type 0) writes one Q8.8 element into the 16384-entry
// feature store and returns nothing; a pool transaction (req_type 1) returns
// one result. Transactions enter a four-entry queue and are executed in order
// by the back end, which writes a load into the store from its idle state. For a
// pool the four region corners are scaled, the bin edges come from 17 steps of
// a one-bit divider and are clipped to the map, and the span is read one element
// per cycle through the single store read port; an empty clipped span skips the
// scan. Rejected pool transactions go straight to the result state. Entries never
// loaded read as unknown. Configuration writes are taken at any time and should
// be issued only while the block is idle.
module roi_max_pooling_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  rmp_pkg::req_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output rmp_pkg::rsp_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rmp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rmp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  rmp_pkg::cfg_t    cfg;
  logic             q_full;
  logic             push;
  rmp_pkg::qentry_t push_data;
  logic             pop;
  rmp_pkg::qentry_t pop_data;
  logic             q_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pooled_rows <= rmp_pkg::POOL_W'(7);
      cfg.pooled_cols <= rmp_pkg::POOL_W'(7);
      cfg.map_scale   <= rmp_pkg::SCALE_W'(4096);
      cfg.map_height  <= rmp_pkg::MAP_W'(32);
      cfg.map_width   <= rmp_pkg::MAP_W'(32);
    end else if (cfg_valid) begin
      case (rmp_pkg::cfg_reg_t'(cfg_index))
        rmp_pkg::REG_POOLED_ROWS: cfg.pooled_rows <= cfg_data[rmp_pkg::POOL_W-1:0];
        rmp_pkg::REG_POOLED_COLS: cfg.pooled_cols <= cfg_data[rmp_pkg::POOL_W-1:0];
        rmp_pkg::REG_MAP_SCALE:   cfg.map_scale   <= cfg_data[rmp_pkg::SCALE_W-1:0];
        rmp_pkg::REG_MAP_HEIGHT:  cfg.map_height  <= cfg_data[rmp_pkg::MAP_W-1:0];
        rmp_pkg::REG_MAP_WIDTH:   cfg.map_width   <= cfg_data[rmp_pkg::MAP_W-1:0];
        default:                  cfg             <= cfg;
      endcase
    end
  end

  rmp_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  rmp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid)
  );

  rmp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/rmp_queue.sv
// ----------------------------------------------------------------------------
// rmp_queue
// Small FIFO of classified transactions between front and back.
// ----------------------------------------------------------------------------
module rmp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rmp_pkg::qentry_t push_data,
  output logic            full,
  input  logic            pop,
  output rmp_pkg::qentry_t pop_data,
  output logic            not_empty
);

  rmp_pkg::qentry_t                  slots [rmp_pkg::QUEUE_DEPTH];
  logic [rmp_pkg::QPTR_W-1:0]        wr_ptr;
  logic [rmp_pkg::QPTR_W-1:0]        rd_ptr;
  logic [rmp_pkg::QCNT_W-1:0]        count;

  assign full      = (count == rmp_pkg::QCNT_W'(rmp_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue pop while empty");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count out of step");

endmodule

>>> rtl/rmp_front.sv
// ----------------------------------------------------------------------------
// rmp_front
// Accepts input transactions and sorts them into load, drop, pool and
// rejected pool before they enter the queue.
// ----------------------------------------------------------------------------
module rmp_front (
  input  logic             in_valid,
  output logic             in_ready,
  input  rmp_pkg::req_t    in_data,
  input  rmp_pkg::cfg_t    cfg,
  input  logic             q_full,
  output logic             push,
  output rmp_pkg::qentry_t push_data
);

  logic [rmp_pkg::POOL_W-1:0] prow;
  logic [rmp_pkg::POOL_W-1:0] pcol;
  logic                       addr_ok;
  logic                       bin_ok;

  always_comb begin
    prow    = rmp_pkg::sat_pool(cfg.pooled_rows);
    pcol    = rmp_pkg::sat_pool(cfg.pooled_cols);
    addr_ok = (int'(in_data.batch_index) < rmp_pkg::MAX_BATCH) &&
              (int'(in_data.channel_index) < rmp_pkg::MAX_CHANNELS);
    bin_ok  = (rmp_pkg::POOL_W'(in_data.bin_row) < prow) &&
              (rmp_pkg::POOL_W'(in_data.bin_col) < pcol);

    push_data.req = in_data;
    if (in_data.req_type == rmp_pkg::REQ_LOAD) begin
      if (addr_ok && (int'(in_data.load_row) < rmp_pkg::MAX_HEIGHT) &&
          (int'(in_data.load_col) < rmp_pkg::MAX_WIDTH)) begin
        push_data.kind = rmp_pkg::KIND_LOAD;
      end else begin
        push_data.kind = rmp_pkg::KIND_DROP;
      end
    end else if (addr_ok && bin_ok) begin
      push_data.kind = rmp_pkg::KIND_POOL;
    end else begin
      push_data.kind = rmp_pkg::KIND_BAD;
    end
  end

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule

>>> rtl/rmp_back.sv
// ----------------------------------------------------------------------------
// rmp_back
// Executes queued transactions: writes loads into the feature store, and for
// a pool transaction scales the region, divides it into bins, scans the bin
// span one read per cycle and keeps the running maximum.
// ----------------------------------------------------------------------------
module rmp_back (
  input  logic             clk,
  input  logic             rst,
  input  rmp_pkg::cfg_t    cfg,
  input  logic             q_valid,
  input  rmp_pkg::qentry_t q_data,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output rmp_pkg::rsp_t    out_data
);

  localparam int L_HS = 0;
  localparam int L_HE = 1;
  localparam int L_WS = 2;
  localparam int L_WE = 3;

  rmp_pkg::back_state_t state;
  rmp_pkg::back_state_t state_next;

  logic signed [rmp_pkg::VALUE_W-1:0] store [rmp_pkg::STORE_DEPTH];
  logic signed [rmp_pkg::VALUE_W-1:0] rdata;
  logic                               rd_pend;
  logic                               mem_we;
  logic                               rd_en;
  logic [rmp_pkg::ADDR_W-1:0]         waddr;
  logic [rmp_pkg::ADDR_W-1:0]         raddr;

  rmp_pkg::req_t                cur;
  logic [rmp_pkg::COORD_W-1:0]  x0, y0, x1, y1;
  logic [rmp_pkg::NUM_W-1:0]    dq  [rmp_pkg::LANES];
  logic [rmp_pkg::REM_W-1:0]    rem [rmp_pkg::LANES];
  logic [rmp_pkg::NUM_W-1:0]    dq_next  [rmp_pkg::LANES];
  logic [rmp_pkg::REM_W-1:0]    rem_next [rmp_pkg::LANES];
  logic [rmp_pkg::REM_W-1:0]    divisor  [rmp_pkg::LANES];
  logic [rmp_pkg::DCNT_W-1:0]   dcnt;
  logic [rmp_pkg::MAP_W-1:0]    hs, he, ws, we;
  logic [rmp_pkg::MAP_W-1:0]    hs_next, he_next, ws_next, we_next;
  logic [rmp_pkg::MAP_W-1:0]    row, col;
  logic signed [rmp_pkg::VALUE_W-1:0] best;
  logic signed [rmp_pkg::VALUE_W-1:0] best_next;
  rmp_pkg::rsp_t                res;

  logic [rmp_pkg::POOL_W-1:0]   prow, pcol;
  logic [rmp_pkg::MAP_W-1:0]    map_h, map_w;
  logic [rmp_pkg::SIZE_W-1:0]   rh, rw;
  logic signed [rmp_pkg::SIZE_W+1:0] dh, dw;
  logic                         span_empty;
  logic                         scan_last;
  logic                         out_free;

  function automatic logic [rmp_pkg::COORD_W-1:0] scale_coord(
      input logic [rmp_pkg::ROI_W-1:0]   c,
      input logic [rmp_pkg::SCALE_W-1:0] s);
    logic [rmp_pkg::PROD_W-1:0] p;
    p = rmp_pkg::PROD_W'(c) * rmp_pkg::PROD_W'(s) +
        rmp_pkg::PROD_W'(1 << (rmp_pkg::ROUND_SHIFT - 1));
    return p[rmp_pkg::ROUND_SHIFT +: rmp_pkg::COORD_W];
  endfunction

  // Geometry from configuration.
  always_comb begin
    prow  = rmp_pkg::sat_pool(cfg.pooled_rows);
    pcol  = rmp_pkg::sat_pool(cfg.pooled_cols);
    map_h = rmp_pkg::sat_map(cfg.map_height, rmp_pkg::MAP_W'(rmp_pkg::MAX_HEIGHT));
    map_w = rmp_pkg::sat_map(cfg.map_width, rmp_pkg::MAP_W'(rmp_pkg::MAX_WIDTH));
    divisor[L_HS] = prow;
    divisor[L_HE] = prow;
    divisor[L_WS] = pcol;
    divisor[L_WE] = pcol;
  end

  // Region size, clamped to at least one cell.
  always_comb begin
    dh = $signed({2'b00, y1}) - $signed({2'b00, y0}) + $signed((rmp_pkg::SIZE_W+2)'(1));
    dw = $signed({2'b00, x1}) - $signed({2'b00, x0}) + $signed((rmp_pkg::SIZE_W+2)'(1));
    rh = (dh < 1) ? rmp_pkg::SIZE_W'(1) : dh[rmp_pkg::SIZE_W-1:0];
    rw = (dw < 1) ? rmp_pkg::SIZE_W'(1) : dw[rmp_pkg::SIZE_W-1:0];
  end

  // One restoring division step per lane.
  always_comb begin
    logic [rmp_pkg::REM_W:0] trial;
    for (int i = 0; i < rmp_pkg::LANES; i++) begin
      trial = {rem[i], dq[i][rmp_pkg::NUM_W-1]};
      if (trial >= {1'b0, divisor[i]}) begin
        rem_next[i] = rmp_pkg::REM_W'(trial - {1'b0, divisor[i]});
        dq_next[i]  = {dq[i][rmp_pkg::NUM_W-2:0], 1'b1};
      end else begin
        rem_next[i] = trial[rmp_pkg::REM_W-1:0];
        dq_next[i]  = {dq[i][rmp_pkg::NUM_W-2:0], 1'b0};
      end
    end
  end

  // Offset by the region start and clip to the map.
  always_comb begin
    hs_next = rmp_pkg::clip_map(rmp_pkg::SUM_W'(dq[L_HS]) + rmp_pkg::SUM_W'(y0), map_h);
    he_next = rmp_pkg::clip_map(rmp_pkg::SUM_W'(dq[L_HE]) + rmp_pkg::SUM_W'(y0), map_h);
    ws_next = rmp_pkg::clip_map(rmp_pkg::SUM_W'(dq[L_WS]) + rmp_pkg::SUM_W'(x0), map_w);
    we_next = rmp_pkg::clip_map(rmp_pkg::SUM_W'(dq[L_WE]) + rmp_pkg::SUM_W'(x0), map_w);
    span_empty = (he_next <= hs_next) || (we_next <= ws_next);
  end

  always_comb begin
    scan_last = (col + 1'b1 == we) && (row + 1'b1 == he);
    out_free  = !out_valid || out_ready;
    best_next = (rd_pend && (rdata > best)) ? rdata : best;
    waddr = {q_data.req.batch_index, q_data.req.channel_index,
             q_data.req.load_row, q_data.req.load_col};
    raddr = {cur.batch_index, cur.channel_index,
             row[rmp_pkg::ROW_W-1:0], col[rmp_pkg::COL_W-1:0]};
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      rmp_pkg::B_IDLE: begin
        if (q_valid) begin
          case (q_data.kind)
            rmp_pkg::KIND_POOL: state_next = rmp_pkg::B_SCALE;
            rmp_pkg::KIND_BAD:  state_next = rmp_pkg::B_DONE;
            default:            state_next = rmp_pkg::B_IDLE;
          endcase
        end
      end
      rmp_pkg::B_SCALE: state_next = rmp_pkg::B_SIZE;
      rmp_pkg::B_SIZE:  state_next = rmp_pkg::B_DIV;
      rmp_pkg::B_DIV: begin
        if (dcnt == rmp_pkg::DCNT_W'(rmp_pkg::DIV_STEPS - 1)) begin
          state_next = rmp_pkg::B_CLIP;
        end
      end
      rmp_pkg::B_CLIP:  state_next = span_empty ? rmp_pkg::B_DONE : rmp_pkg::B_SCAN;
      rmp_pkg::B_SCAN:  state_next = scan_last ? rmp_pkg::B_DRAIN : rmp_pkg::B_SCAN;
      rmp_pkg::B_DRAIN: state_next = rmp_pkg::B_DONE;
      rmp_pkg::B_DONE:  state_next = out_free ? rmp_pkg::B_IDLE : rmp_pkg::B_DONE;
      default:          state_next = rmp_pkg::B_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop    = 1'b0;
    mem_we = 1'b0;
    rd_en  = 1'b0;
    case (state)
      rmp_pkg::B_IDLE: begin
        pop    = q_valid;
        mem_we = q_valid && (q_data.kind == rmp_pkg::KIND_LOAD);
      end
      rmp_pkg::B_SCAN: rd_en = 1'b1;
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[waddr] <= q_data.req.load_value;
    end
    if (rd_en) begin
      rdata <= store[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= rmp_pkg::B_IDLE;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      rmp_pkg::B_IDLE: begin
        cur <= q_data.req;
        res.pooled_value <= '0;
        res.empty_bin    <= 1'b0;
        res.bad_request  <= 1'b1;
      end
      rmp_pkg::B_SCALE: begin
        x0 <= scale_coord(cur.roi_left, cfg.map_scale);
        y0 <= scale_coord(cur.roi_top, cfg.map_scale);
        x1 <= scale_coord(cur.roi_right, cfg.map_scale);
        y1 <= scale_coord(cur.roi_bottom, cfg.map_scale);
      end
      rmp_pkg::B_SIZE: begin
        dq[L_HS] <= rmp_pkg::NUM_W'(cur.bin_row) * rmp_pkg::NUM_W'(rh);
        dq[L_HE] <= (rmp_pkg::NUM_W'(cur.bin_row) + 1'b1) * rmp_pkg::NUM_W'(rh) +
                    rmp_pkg::NUM_W'(prow) - 1'b1;
        dq[L_WS] <= rmp_pkg::NUM_W'(cur.bin_col) * rmp_pkg::NUM_W'(rw);
        dq[L_WE] <= (rmp_pkg::NUM_W'(cur.bin_col) + 1'b1) * rmp_pkg::NUM_W'(rw) +
                    rmp_pkg::NUM_W'(pcol) - 1'b1;
        for (int i = 0; i < rmp_pkg::LANES; i++) begin
          rem[i] <= '0;
        end
        dcnt <= '0;
      end
      rmp_pkg::B_DIV: begin
        for (int i = 0; i < rmp_pkg::LANES; i++) begin
          dq[i]  <= dq_next[i];
          rem[i] <= rem_next[i];
        end
        dcnt <= dcnt + 1'b1;
      end
      rmp_pkg::B_CLIP: begin
        hs   <= hs_next;
        he   <= he_next;
        ws   <= ws_next;
        we   <= we_next;
        row  <= hs_next;
        col  <= ws_next;
        best <= {1'b1, {(rmp_pkg::VALUE_W-1){1'b0}}};
        res.pooled_value <= '0;
        res.empty_bin    <= 1'b1;
        res.bad_request  <= 1'b0;
      end
      rmp_pkg::B_SCAN: begin
        best <= best_next;
        if (col + 1'b1 == we) begin
          col <= ws;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
      rmp_pkg::B_DRAIN: begin
        res.pooled_value <= best_next;
        res.empty_bin    <= 1'b0;
        res.bad_request  <= 1'b0;
      end
      default: begin
        best <= best;
      end
    endcase
  end

  // Output register; the next transaction proceeds while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == rmp_pkg::B_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == rmp_pkg::B_DONE && out_free) begin
      out_data <= res;
    end
  end

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == rmp_pkg::B_IDLE))
    else $error("store written outside idle");

  a_scan_in_span: assert property (@(posedge clk) disable iff (rst)
    (state == rmp_pkg::B_SCAN) |-> (row < he && col < we && row >= hs && col >= ws))
    else $error("scan address outside bin span");

  a_drain_has_data: assert property (@(posedge clk) disable iff (rst)
    (state == rmp_pkg::B_DRAIN) |-> rd_pend)
    else $error("drain without pending read");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == rmp_pkg::B_CLIP) |-> (dcnt == rmp_pkg::DCNT_W'(rmp_pkg::DIV_STEPS)))
    else $error("division ended early");

endmodule

>>> verif/rmp_checker.sv
// ----------------------------------------------------------------------------
// rmp_checker
// Watches the request, response and register channels of the ROI max pooling
// core, keeps its own copy of the feature map and registers, predicts each
// pool result and compares responses in order.
// ----------------------------------------------------------------------------
module rmp_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  rmp_pkg::req_t                  in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  rmp_pkg::rsp_t                  out_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [rmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmp_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding
);

  logic [rmp_pkg::VALUE_W-1:0] fmap [rmp_pkg::STORE_DEPTH];
  logic [rmp_pkg::POOL_W-1:0]  bins_down;
  logic [rmp_pkg::POOL_W-1:0]  bins_across;
  logic [rmp_pkg::SCALE_W-1:0] scale;
  logic [rmp_pkg::MAP_W-1:0]   rows_used;
  logic [rmp_pkg::MAP_W-1:0]   cols_used;
  rmp_pkg::rsp_t               pending_max[$];

  function automatic int to_cell(input logic [rmp_pkg::ROI_W-1:0] coord);
    longint prod;
    prod = longint'(coord) * longint'(scale);
    return int'((prod + (64'd1 << 19)) >> 20);
  endfunction

  function automatic int clamp(input int v, input int hi);
    if (v < 0) return 0;
    return (v > hi) ? hi : v;
  endfunction

  function automatic rmp_pkg::rsp_t bin_max(input rmp_pkg::req_t r);
    rmp_pkg::rsp_t res;
    int   ph, pw, h, w, x0, y0, x1, y1, rh, rw, hs, he, ws, we, best, v;
    res = '0;
    ph = (bins_down > rmp_pkg::MAX_POOLED) ? rmp_pkg::MAX_POOLED : int'(bins_down);
    pw = (bins_across > rmp_pkg::MAX_POOLED) ? rmp_pkg::MAX_POOLED : int'(bins_across);
    if (int'(r.bin_row) >= ph || int'(r.bin_col) >= pw) begin
      res.bad_request = 1'b1;
      return res;
    end
    x0 = to_cell(r.roi_left);
    y0 = to_cell(r.roi_top);
    x1 = to_cell(r.roi_right);
    y1 = to_cell(r.roi_bottom);
    rh = (y1 - y0 + 1 < 1) ? 1 : y1 - y0 + 1;
    rw = (x1 - x0 + 1 < 1) ? 1 : x1 - x0 + 1;
    h = (rows_used > rmp_pkg::MAX_HEIGHT) ? rmp_pkg::MAX_HEIGHT : int'(rows_used);
    w = (cols_used > rmp_pkg::MAX_WIDTH) ? rmp_pkg::MAX_WIDTH : int'(cols_used);
    hs = clamp(int'(r.bin_row) * rh / ph + y0, h);
    he = clamp(((int'(r.bin_row) + 1) * rh + ph - 1) / ph + y0, h);
    ws = clamp(int'(r.bin_col) * rw / pw + x0, w);
    we = clamp(((int'(r.bin_col) + 1) * rw + pw - 1) / pw + x0, w);
    if (he <= hs || we <= ws) begin
      res.empty_bin = 1'b1;
      return res;
    end
    best = -32768;
    for (int y = hs; y < he; y++) begin
      for (int x = ws; x < we; x++) begin
        v = int'($signed(fmap[{r.batch_index, r.channel_index, 5'(y), 5'(x)}]));
        if (v > best) best = v;
      end
    end
    res.pooled_value = rmp_pkg::VALUE_W'(best);
    return res;
  endfunction

  always @(posedge clk) begin
    rmp_pkg::rsp_t want;
    if (rst) begin
      bins_down   = 5'd7;
      bins_across = 5'd7;
      scale       = 16'd4096;
      rows_used   = 6'd32;
      cols_used   = 6'd32;
      pending_max.delete();
      mismatches  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (rmp_pkg::cfg_reg_t'(cfg_index))
          rmp_pkg::REG_POOLED_ROWS: bins_down   = cfg_data[rmp_pkg::POOL_W-1:0];
          rmp_pkg::REG_POOLED_COLS: bins_across = cfg_data[rmp_pkg::POOL_W-1:0];
          rmp_pkg::REG_MAP_SCALE:   scale       = cfg_data;
          rmp_pkg::REG_MAP_HEIGHT:  rows_used   = cfg_data[rmp_pkg::MAP_W-1:0];
          rmp_pkg::REG_MAP_WIDTH:   cols_used   = cfg_data[rmp_pkg::MAP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (in_data.req_type == rmp_pkg::REQ_LOAD)
          fmap[{in_data.batch_index, in_data.channel_index, in_data.load_row,
                in_data.load_col}] = in_data.load_value;
        else
          pending_max.push_back(bin_max(in_data));
      end
      if (out_valid && out_ready) begin
        if (pending_max.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected response %h", out_data);
        end else begin
          want = pending_max.pop_front();
          if (out_data.pooled_value !== want.pooled_value ||
              out_data.empty_bin !== want.empty_bin ||
              out_data.bad_request !== want.bad_request) begin
            mismatches++;
            if (mismatches <= 10)
              $display("response mismatch: value %h/%h empty %b/%b bad %b/%b (exp/act)",
                       want.pooled_value, out_data.pooled_value, want.empty_bin,
                       out_data.empty_bin, want.bad_request, out_data.bad_request);
          end
        end
      end
    end
    outstanding = pending_max.size();
  end

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the ROI max pooling core: directed corner transactions, then
// random pool regions and loads over several register settings, with feature elements
// loaded on demand so that no pool ever reads an unloaded element.
// ----------------------------------------------------------------------------
module testbench;

  localparam int STALL_LIMIT = 20000;
  localparam int REQ_BITS    = $bits(rmp_pkg::req_t);

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  rmp_pkg::req_t                  in_data;
  logic                           out_valid;
  logic                           out_ready;
  rmp_pkg::rsp_t                  out_data;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [rmp_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [rmp_pkg::CFG_DATA_W-1:0] cfg_data;
  int                             mismatches;
  int                             outstanding;

  // register copy used to steer stimulus and on-demand loads
  logic [rmp_pkg::POOL_W-1:0]  bins_down;
  logic [rmp_pkg::POOL_W-1:0]  bins_across;
  logic [rmp_pkg::SCALE_W-1:0] scale;
  logic [rmp_pkg::MAP_W-1:0]   rows_used;
  logic [rmp_pkg::MAP_W-1:0]   cols_used;
  bit                          loaded [rmp_pkg::STORE_DEPTH];
  bit                          steady;
  bit                          hold_out;
  int                          span_div;
  int                          quiet;

  roi_max_pooling_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rmp_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic offer(input rmp_pkg::req_t r);
    int g;
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic load_cell(input logic b, input logic [2:0] c, input logic [4:0] y,
                           input logic [4:0] x, input logic [15:0] v);
    rmp_pkg::req_t r;
    r = rmp_pkg::req_t'(REQ_BITS'({$urandom, $urandom, $urandom, $urandom}));
    r.req_type      = rmp_pkg::REQ_LOAD;
    r.batch_index   = b;
    r.channel_index = c;
    r.load_row      = y;
    r.load_col      = x;
    r.load_value    = v;
    loaded[{b, c, y, x}] = 1'b1;
    offer(r);
  endtask

  function automatic int to_cell(input logic [rmp_pkg::ROI_W-1:0] coord);
    return int'((longint'(coord) * longint'(scale) + (64'd1 << 19)) >> 20);
  endfunction

  function automatic int clamp(input int v, input int hi);
    if (v < 0) return 0;
    return (v > hi) ? hi : v;
  endfunction

  // load every element of the bin's clipped window that has never been loaded
  task automatic send_pool(input rmp_pkg::req_t r);
    int ph, pw, h, w, x0, y0, rh, rw, hs, he, ws, we;
    r.req_type = rmp_pkg::REQ_POOL;
    ph = (bins_down > rmp_pkg::MAX_POOLED) ? rmp_pkg::MAX_POOLED : int'(bins_down);
    pw = (bins_across > rmp_pkg::MAX_POOLED) ? rmp_pkg::MAX_POOLED : int'(bins_across);
    if (int'(r.bin_row) < ph && int'(r.bin_col) < pw) begin
      x0 = to_cell(r.roi_left);
      y0 = to_cell(r.roi_top);
      rh = to_cell(r.roi_bottom) - y0 + 1;
      rw = to_cell(r.roi_right) - x0 + 1;
      if (rh < 1) rh = 1;
      if (rw < 1) rw = 1;
      h = (rows_used > rmp_pkg::MAX_HEIGHT) ? rmp_pkg::MAX_HEIGHT : int'(rows_used);
      w = (cols_used > rmp_pkg::MAX_WIDTH) ? rmp_pkg::MAX_WIDTH : int'(cols_used);
      hs = clamp(int'(r.bin_row) * rh / ph + y0, h);
      he = clamp(((int'(r.bin_row) + 1) * rh + ph - 1) / ph + y0, h);
      ws = clamp(int'(r.bin_col) * rw / pw + x0, w);
      we = clamp(((int'(r.bin_col) + 1) * rw + pw - 1) / pw + x0, w);
      for (int y = hs; y < he; y++)
        for (int x = ws; x < we; x++)
          if (!loaded[{r.batch_index, r.channel_index, 5'(y), 5'(x)}])
            load_cell(r.batch_index, r.channel_index, 5'(y), 5'(x), 16'($urandom));
    end
    offer(r);
  endtask

  task automatic pool_at(input logic [15:0] l, input logic [15:0] t, input logic [15:0] rt,
                         input logic [15:0] bt, input logic [3:0] br, input logic [3:0] bc);
    rmp_pkg::req_t r;
    r = rmp_pkg::req_t'(REQ_BITS'({$urandom, $urandom, $urandom, $urandom}));
    r.roi_left   = l;
    r.roi_top    = t;
    r.roi_right  = rt;
    r.roi_bottom = bt;
    r.bin_row    = br;
    r.bin_col    = bc;
    send_pool(r);
  endtask

  // valid stays high across a burst of writes; the caller drops it
  task automatic write_reg(input rmp_pkg::cfg_reg_t idx,
                           input logic [rmp_pkg::CFG_DATA_W-1:0] v);
    cfg_index <= idx;
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // trailing loads may still be in the queue
    repeat (40) @(posedge clk);
  endtask

  task automatic set_regs(input int pr, input int pc, input int sc, input int mh, input int mw);
    drain();
    bins_down   = rmp_pkg::POOL_W'(pr);
    bins_across = rmp_pkg::POOL_W'(pc);
    scale       = rmp_pkg::SCALE_W'(sc);
    rows_used   = rmp_pkg::MAP_W'(mh);
    cols_used   = rmp_pkg::MAP_W'(mw);
    write_reg(rmp_pkg::REG_POOLED_ROWS, rmp_pkg::CFG_DATA_W'(pr));
    write_reg(rmp_pkg::REG_POOLED_COLS, rmp_pkg::CFG_DATA_W'(pc));
    write_reg(rmp_pkg::REG_MAP_SCALE, rmp_pkg::CFG_DATA_W'(sc));
    write_reg(rmp_pkg::REG_MAP_HEIGHT, rmp_pkg::CFG_DATA_W'(mh));
    write_reg(rmp_pkg::REG_MAP_WIDTH, rmp_pkg::CFG_DATA_W'(mw));
    cfg_valid <= 1'b0;
  endtask

  // mostly regions that land on the map, some raw noise and inverted corners
  task automatic random_pool();
    rmp_pkg::req_t r;
    longint        reach;
    int            a, b, mode;
    r = rmp_pkg::req_t'(REQ_BITS'({$urandom, $urandom, $urandom, $urandom}));
    mode = $urandom_range(0, 9);
    if (mode > 0) begin
      reach = (scale == 0) ? 65535 : ((longint'(rmp_pkg::MAX_WIDTH) << 20) / scale);
      if (reach > 65535) reach = 65535;
      a = $urandom_range(0, int'(reach));
      b = a + $urandom_range(0, int'(reach) / span_div);
      if (b > 65535) b = 65535;
      r.roi_left  = 16'(a);
      r.roi_right = 16'(b);
      a = $urandom_range(0, int'(reach));
      b = a + $urandom_range(0, int'(reach) / span_div);
      if (b > 65535) b = 65535;
      r.roi_top    = 16'(a);
      r.roi_bottom = 16'(b);
      if (mode == 1) begin
        r.roi_left  = 16'(b);
        r.roi_right = 16'(a);
      end
      if ($urandom_range(0, 7) != 0) begin
        r.bin_row = 4'($urandom_range(0, (bins_down > 1) ? int'(bins_down) - 1 : 0));
        r.bin_col = 4'($urandom_range(0, (bins_across > 1) ? int'(bins_across) - 1 : 0));
      end
    end
    send_pool(r);
  endtask

  task automatic random_phase(input int count);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2 && $urandom_range(0, 1) == 1) begin
        // let every outstanding pool come back before going on
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      if (i % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0)
        load_cell(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 16'($urandom));
      else
        random_pool();
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_out) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_out = 1'b0;
      end
      if (!steady && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= rmp_pkg::REG_POOLED_ROWS;
    cfg_data  <= '0;
    steady    = 1'b0;
    hold_out  = 1'b0;
    span_div  = 4;
    bins_down   = 5'd7;
    bins_across = 5'd7;
    scale       = 16'd4096;
    rows_used   = 6'd32;
    cols_used   = 6'd32;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // corner transactions under the reset register values
    load_cell(1'b1, 3'd7, 5'd31, 5'd31, 16'h7fff);
    load_cell(1'b0, 3'd0, 5'd0, 5'd0, 16'h8000);
    pool_at(16'd0, 16'd0, 16'd0, 16'd0, 4'd0, 4'd0);
    pool_at(16'd7936, 16'd7936, 16'd7936, 16'd7936, 4'd6, 4'd6);
    pool_at(16'd0, 16'd0, 16'd1000, 16'd1000, 4'd7, 4'd0);
    pool_at(16'd0, 16'd0, 16'd1000, 16'd1000, 4'd0, 4'd15);
    pool_at(16'd8000, 16'd100, 16'd100, 16'd3000, 4'd3, 4'd2);
    pool_at(16'hffff, 16'hffff, 16'hffff, 16'hffff, 4'd0, 4'd0);
    pool_at(16'd128, 16'd127, 16'd2000, 16'd1500, 4'd6, 4'd0);
    pool_at(16'd0, 16'd0, 16'hffff, 16'hffff, 4'd6, 4'd6);

    set_regs(4, 4, 65535, 8, 8);
    hold_out = 1'b1;
    random_phase(140);
    set_regs(1, 1, 0, 1, 1);
    random_phase(60);
    set_regs(16, 16, 20000, 12, 6);
    random_phase(140);
    span_div = 8;
    set_regs(31, 20, 9000, 63, 40);
    random_phase(140);
    span_div = 4;
    set_regs(0, 3, 30000, 8, 8);
    random_phase(60);
    set_regs(5, 2, 50000, 0, 5);
    random_phase(60);
    set_regs(3, 16, 8192, 5, 32);
    random_phase(140);
    set_regs(7, 7, 4096, 32, 32);
    random_phase(60);

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
